FILE: design/qau_pkg.sv
// Shared definitions for the quaternion arithmetic unit.
// Operation codes and reset constants; no dependencies.
`default_nettype none

package qau_pkg;

   // operation selector carried in req_tuser
   typedef enum logic [2:0] {
      OP_MUL   = 3'd0,
      OP_SCALE = 3'd1,
      OP_ADD   = 3'd2,
      OP_SUB   = 3'd3,
      OP_CONJ  = 3'd4,
      OP_INV   = 3'd5,
      OP_NORM  = 3'd6
   } op_type;

   localparam int          OP_W      = 3;
   localparam int          TOL_W     = 16;
   localparam logic [15:0] TOL_RESET = 16'd66;

endpackage

`default_nettype wire

FILE: design/qau_div_lane.sv
// One restoring-division lane, one quotient bit per register stage.
// Standalone; instantiated four times by quaternion_arithmetic_unit_top.
`default_nettype none

module qau_div_lane #(
   parameter int QW = 32,
   parameter int DW = 64
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [DW-1:0] in_rem,   // high part of dividend, below in_den
   input  wire logic [QW-1:0] in_lo,    // low dividend bits, brought down one a stage
   input  wire logic [DW-1:0] in_den,
   output logic      [QW-1:0] out_q
);

   typedef struct packed {
      logic [DW-1:0] rem;
      logic [QW-1:0] lo;
      logic [QW-1:0] q;
      logic [DW-1:0] den;
   } dv_type;

   dv_type st_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_step
      dv_type  src;
      dv_type  st_in;
      logic [DW:0] r2;
      logic        ge;

      if (k == 0) begin : g_first
         assign src = '{rem: in_rem, lo: in_lo, q: '0, den: in_den};
      end else begin : g_next
         assign src = st_ff[k-1];
      end

      // shift in one dividend bit, trial subtract
      always_comb begin
         r2           = {src.rem, src.lo[QW-1-k]};
         ge           = (r2 >= {1'b0, src.den});
         st_in        = src;
         st_in.rem    = ge ? DW'(r2 - {1'b0, src.den}) : DW'(r2);
         st_in.q      = {src.q[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[k] <= st_in;
         end
      end
   end

   assign out_q = st_ff[QW-1].q;

endmodule

`default_nettype wire

FILE: design/quaternion_arithmetic_unit_top.sv
// Quaternion arithmetic unit, signed fixed point, fully pipelined.
// Depends on qau_pkg and qau_div_lane.
//
//   port group | dir | contents
//   req_*      | in  | tdata: a_real,a_i,a_j,a_k,b_real,b_i,b_j,b_k,factor; tuser: operation
//   rsp_*      | out | tdata: out_real,out_i,out_j,out_k,length_a,is_unit,zero_length_error
//   csr_*      | in  | write-only unit_tolerance
//
// One beat per cycle while the output accepts results; the depth is set by the
// digit-per-stage square root followed by the bit-per-stage dividers.
// Reset clears every valid bit and loads unit_tolerance with 66.
// A waiting result stalls the whole pipe while its tail stage holds a beat;
// an empty tail slot lets the pipe move, and input is refused while it stalls.
`default_nettype none

module quaternion_arithmetic_unit_top #(
   parameter int COMPONENT_WIDTH = 32,
   parameter int FRACTION_BITS   = 16,
   localparam int REQ_W = ((9 * COMPONENT_WIDTH + 7) / 8) * 8,
   localparam int RSP_W = ((5 * COMPONENT_WIDTH + 1 + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // a_real, a_i, a_j, a_k, b_real, b_i, b_j, b_k, factor (low to high)
   input  wire logic [REQ_W-1:0] req_tdata,
   // operation
   input  wire logic [2:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // out_real, out_i, out_j, out_k, length_a, is_unit, zero_length_error
   output logic      [RSP_W-1:0] rsp_tdata,
   input  wire logic             csr_wr_en,
   input  wire logic [15:0]      csr_wr_data
);

   localparam int W  = COMPONENT_WIDTH;
   localparam int F  = FRACTION_BITS;
   localparam int DW = 2 * W;
   localparam int SW = 2 * W + 1;
   localparam int PW = 2 * W + 3;
   localparam int RW = W + 2;
   localparam int HW = 2 * F;
   localparam int NW = W + 2 * F;
   localparam int CW = (HW > DW) ? HW : DW;

   typedef logic [3:0][W-1:0] quat_type;

   typedef struct packed {
      logic                  v;
      logic [2:0]            op;
      quat_type              a;
      quat_type              r;
      logic [15:0][DW-1:0]   prod;
      logic [3:0][DW-1:0]    sq;
   } s1_type;

   typedef struct packed {
      logic        v;
      logic [2:0]  op;
      quat_type    a;
      quat_type    r;
      logic [SW-1:0] s;
   } s2_type;

   typedef struct packed {
      logic          v;
      logic [2:0]    op;
      quat_type      a;
      quat_type      r;
      logic [SW-1:0] s;
      logic          unit;
      logic          lensat;
      logic [RW-1:0] rem;
      logic [W-1:0]  root;
   } sq_type;

   typedef struct packed {
      logic        v;
      logic [2:0]  op;
      quat_type    r;
      logic        unit;
      logic [W-2:0] len;
      logic        err;
      logic        carry;
      logic [3:0]  neg;
      logic [3:0]  ovf;
   } tl_type;

   typedef struct packed {
      tl_type               tl;
      logic [3:0][DW-1:0]   rem0;
      quat_type             lo;
      logic [DW-1:0]        den;
   } pr_type;

   typedef struct packed {
      logic         v;
      quat_type     r;
      logic [W-2:0] len;
      logic         unit;
      logic         err;
   } out_type;

   // saturate a wide signed value to one component
   function automatic logic [W-1:0] sat_f(input logic signed [PW-1:0] v);
      if ((&v[PW-1:W-1]) || !(|v[PW-1:W-1])) begin
         return v[W-1:0];
      end
      return v[PW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
   endfunction

   logic [15:0] tol_ff;
   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   sq_type  sq_ff [W+1];
   sq_type  sq0_in;
   pr_type  pr_ff, pr_in;
   tl_type  dl_ff [W];
   out_type out_ff, out_in;
   quat_type lane_q;
   logic    en, out_en;

   // pipe moves when the output can take a beat or the tail slot is empty
   assign out_en     = !out_ff.v || rsp_tready;
   assign en         = out_en || !dl_ff[W-1].v;
   assign req_tready = en;

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= qau_pkg::TOL_RESET;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   // stage 1: multipliers and the simple operations
   always_comb begin
      logic signed [W-1:0]  ai, bi, yj;
      logic signed [DW-1:0] pp;
      s1_in    = '0;
      s1_in.v  = req_tvalid;
      s1_in.op = req_tuser;
      for (int i = 0; i < 4; i++) begin
         ai = req_tdata[i*W +: W];
         bi = req_tdata[(4+i)*W +: W];
         s1_in.a[i] = ai;
         pp = ai * ai;
         s1_in.sq[i] = pp;
         for (int j = 0; j < 4; j++) begin
            yj = (req_tuser == qau_pkg::OP_SCALE) ? req_tdata[8*W +: W]
                                                  : req_tdata[(4+j)*W +: W];
            pp = ai * yj;
            s1_in.prod[4*i+j] = pp;
         end
         case (req_tuser)
            qau_pkg::OP_ADD:  s1_in.r[i] = sat_f(PW'(ai) + PW'(bi));
            qau_pkg::OP_SUB:  s1_in.r[i] = sat_f(PW'(ai) - PW'(bi));
            qau_pkg::OP_CONJ: s1_in.r[i] = (i == 0) ? ai : sat_f(-PW'(ai));
            default:          s1_in.r[i] = '0;
         endcase
      end
   end

   // stage 2: product sums and the squared length
   always_comb begin
      logic signed [PW-1:0] p [16];
      logic signed [PW-1:0] acc [4];
      for (int n = 0; n < 16; n++) begin
         p[n] = PW'($signed(s1_ff.prod[n]));
      end
      acc[0] = p[0]  - p[5]  - p[10] - p[15];
      acc[1] = p[1]  + p[4]  + p[11] - p[14];
      acc[2] = p[2]  - p[7]  + p[8]  + p[13];
      acc[3] = p[3]  + p[6]  - p[9]  + p[12];
      s2_in    = '0;
      s2_in.v  = s1_ff.v;
      s2_in.op = s1_ff.op;
      s2_in.a  = s1_ff.a;
      s2_in.s  = SW'(s1_ff.sq[0]) + SW'(s1_ff.sq[1]) + SW'(s1_ff.sq[2]) + SW'(s1_ff.sq[3]);
      for (int i = 0; i < 4; i++) begin
         case (s1_ff.op)
            qau_pkg::OP_MUL:   s2_in.r[i] = sat_f(acc[i] >>> F);
            qau_pkg::OP_SCALE: s2_in.r[i] = sat_f(p[4*i] >>> F);
            default:           s2_in.r[i] = s1_ff.r[i];
         endcase
      end
   end

   // stage 3: unit check, length saturation, root init
   always_comb begin
      logic [SW-1:0] l2, l2_dev;
      logic [SW-1:0] one;
      one          = SW'(1) << F;
      l2           = s2_ff.s >> F;
      l2_dev       = (l2 >= one) ? (l2 - one) : (one - l2);
      sq0_in       = '0;
      sq0_in.v     = s2_ff.v;
      sq0_in.op    = s2_ff.op;
      sq0_in.a     = s2_ff.a;
      sq0_in.r     = s2_ff.r;
      sq0_in.s     = s2_ff.s;
      sq0_in.unit  = !s2_ff.s[SW-1] && (l2_dev <= SW'(tol_ff));
      sq0_in.lensat = s2_ff.s[SW-1] || (s2_ff.s >= (SW'(1) << (DW - 2)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.v    <= 1'b0;
         s2_ff.v    <= 1'b0;
         sq_ff[0].v <= 1'b0;
      end else if (en) begin
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         sq_ff[0] <= sq0_in;
      end
   end

   // square root: one result bit per stage, most significant first
   for (genvar k = 0; k < W; k++) begin : g_sqrt
      localparam int M = W - 1 - k;
      sq_type        nx;
      logic [RW+1:0] r2, t;
      always_comb begin
         r2 = {sq_ff[k].rem, sq_ff[k].s[2*M+1 -: 2]};
         t  = (RW+2)'({sq_ff[k].root, 2'b01});
         nx = sq_ff[k];
         if (r2 >= t) begin
            nx.rem  = RW'(r2 - t);
            nx.root = {sq_ff[k].root[W-2:0], 1'b1};
         end else begin
            nx.rem  = RW'(r2);
            nx.root = {sq_ff[k].root[W-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_ff[k+1].v <= 1'b0;
         end else if (en) begin
            sq_ff[k+1] <= nx;
         end
      end
   end

   // divider setup: magnitudes, dividend split, divisor, overflow
   always_comb begin
      logic          carry, inv, negate;
      logic [W:0]    root_f;
      logic [W-1:0]  ai, mag;
      logic [NW-1:0] num;
      carry  = sq_ff[W].s[SW-1];
      inv    = (sq_ff[W].op == qau_pkg::OP_INV);
      root_f = carry ? {1'b1, {W{1'b0}}} : {1'b0, sq_ff[W].root};
      pr_in          = '0;
      pr_in.tl.v     = sq_ff[W].v;
      pr_in.tl.op    = sq_ff[W].op;
      pr_in.tl.r     = sq_ff[W].r;
      pr_in.tl.unit  = sq_ff[W].unit;
      pr_in.tl.carry = carry;
      pr_in.tl.len   = sq_ff[W].lensat ? {(W-1){1'b1}} : sq_ff[W].root[W-2:0];
      pr_in.tl.err   = (inv || (sq_ff[W].op == qau_pkg::OP_NORM)) && (sq_ff[W].s == '0);
      pr_in.den      = inv ? sq_ff[W].s[DW-1:0] : DW'(root_f);
      for (int i = 0; i < 4; i++) begin
         ai     = sq_ff[W].a[i];
         negate = inv && (i != 0);
         mag    = ai[W-1] ? (~ai + W'(1)) : ai;
         pr_in.tl.neg[i] = negate ? (!ai[W-1] && (ai != '0)) : ai[W-1];
         num    = inv ? (NW'(mag) << HW) : (NW'(mag) << F);
         pr_in.tl.ovf[i] = (CW'(num[NW-1:W]) >= CW'(pr_in.den));
         pr_in.rem0[i]   = pr_in.tl.ovf[i] ? '0 : DW'(num[NW-1:W]);
         pr_in.lo[i]     = num[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_ff.tl.v <= 1'b0;
      end else if (en) begin
         pr_ff <= pr_in;
      end
   end

   // four division lanes
   for (genvar i = 0; i < 4; i++) begin : g_lane
      qau_div_lane #(
         .QW (W),
         .DW (DW)
      ) u_lane (
         .clock  (clock),
         .en     (en),
         .in_rem (pr_ff.rem0[i]),
         .in_lo  (pr_ff.lo[i]),
         .in_den (pr_ff.den),
         .out_q  (lane_q[i])
      );
   end

   // side payload travels beside the lanes
   for (genvar k = 0; k < W; k++) begin : g_delay
      always_ff @(posedge clock) begin
         if (reset) begin
            dl_ff[k].v <= 1'b0;
         end else if (en) begin
            dl_ff[k] <= (k == 0) ? pr_ff.tl : dl_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   // final select and saturation of quotients
   always_comb begin
      logic         big;
      logic [W-1:0] qv, dv;
      out_in      = '0;
      out_in.v    = dl_ff[W-1].v;
      out_in.len  = dl_ff[W-1].len;
      out_in.unit = dl_ff[W-1].unit;
      out_in.err  = dl_ff[W-1].err;
      for (int i = 0; i < 4; i++) begin
         qv  = lane_q[i];
         big = dl_ff[W-1].ovf[i] || qv[W-1];
         if (dl_ff[W-1].neg[i]) begin
            dv = big ? {1'b1, {(W-1){1'b0}}} : (W'(0) - qv);
         end else begin
            dv = big ? {1'b0, {(W-1){1'b1}}} : qv;
         end
         case (dl_ff[W-1].op)
            qau_pkg::OP_INV:
               out_in.r[i] = (dl_ff[W-1].err || dl_ff[W-1].carry) ? '0 : dv;
            qau_pkg::OP_NORM:
               out_in.r[i] = dl_ff[W-1].err ? '0 : dv;
            default:
               out_in.r[i] = dl_ff[W-1].r[i];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.v <= 1'b0;
      end else if (out_en) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_ff.v;
   assign rsp_tdata  = RSP_W'({out_ff.err, out_ff.unit, out_ff.len, out_ff.r});

`ifndef SYNTH
   // zero length forces a zero quaternion
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_ff.err) |-> (out_ff.r == '0))
      else $error("zero-length beat carries a nonzero quaternion");

   // zero length means the reported length is zero too
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_ff.err) |-> (out_ff.len == '0))
      else $error("zero-length beat reports a nonzero length");

   // nothing leaves the pipe right after reset
   assert property (@(posedge clock) (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire
